// ----- hdl/tsc_pkg.sv -----
// Shared constants, types and elaboration-time functions for the degree-input
// sine/cosine/tangent series evaluator. Depends on nothing.
package tsc_pkg;

	// Series and format settings
	localparam int SINCOS_TERMS     = 16;
	localparam int TAN_TERMS        = 15;
	localparam int ANGLE_FRAC_BITS  = 16;
	localparam int RESULT_FRAC_BITS = 30;

	localparam int WORK_FRAC = 52;
	localparam int COEF_FRAC = 62;
	localparam int TAN_FRAC  = 16;

	// Port widths
	localparam int ANGLE_W  = 26;
	localparam int RESULT_W = 32;

	// Constant divisors of the series terms fit in this many bits
	localparam int DIV_W       = 11;
	// Division by reciprocal multiply, one 16-bit quotient digit per two stages
	localparam int DIG_W       = 16;
	localparam int DIV_NUM_W   = DIV_W + DIG_W;
	localparam int DIV_MAGIC_W = DIV_NUM_W + 1;
	localparam int DIV_PROD_W  = DIV_NUM_W + DIV_MAGIC_W;
	localparam int DIV_STAGES  = 2 * (64 / DIG_W);

	// One step instance per series term after the first
	localparam int NUM_STEPS = ((SINCOS_TERMS > TAN_TERMS) ? SINCOS_TERMS : TAN_TERMS) - 1;

	localparam logic [63:0] PI_Q62      = 64'hC90F_DAA2_2168_C235;
	localparam logic [63:0] DEG2RAD_Q62 = (PI_Q62 + 64'd90) / 64'd180;
	localparam logic [63:0] MAG_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONE_WORK    = 64'd1 << WORK_FRAC;
	localparam logic signed [63:0] FULL32 = 64'sd2147483647;

	localparam logic [5:0] X_SHIFT    = 6'(COEF_FRAC + ANGLE_FRAC_BITS - WORK_FRAC);
	localparam logic [5:0] WORK_SHIFT = 6'(WORK_FRAC);

	// Context carried down the term pipeline
	typedef struct packed {
		logic [63:0] x_mag;
		logic        x_neg;
		logic [63:0] x2;
		logic        d_neg;
		logic        big;
		logic [63:0] cos_mag;
		logic        cos_neg;
		logic [63:0] cos_sum;
		logic [63:0] sin_mag;
		logic        sin_neg;
		logic [63:0] sin_sum;
		logic [63:0] tan_p;
	} ctx_t;

	// Per-step constants
	typedef struct packed {
		logic [DIV_W-1:0]       cos_div;
		logic [DIV_MAGIC_W-1:0] cos_magic;
		logic [5:0]             cos_sh;
		logic [DIV_W-1:0]       sin_div;
		logic [DIV_MAGIC_W-1:0] sin_magic;
		logic [5:0]             sin_sh;
		logic [63:0]            tan_coef;
		logic                   sc_en;
		logic                   tan_en;
	} step_cfg_t;

	// Value / 2^s rounded half away from zero, magnitude capped
	function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
		input int s);
		logic [63:0] m;
		m = v[63] ? 64'(-v) : 64'(v);
		m = (m >> s) + ((m >> (s - 1)) & 64'd1);
		if (m > MAG_MAX)
			m = MAG_MAX;
		return v[63] ? $signed(-m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
		input logic signed [63:0] lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// Reciprocal of divisor d, exact floor division of any DIV_NUM_W-bit value
	function automatic logic [DIV_MAGIC_W-1:0] div_magic(input int d);
		logic [63:0] q;
		q = (64'd1 << (DIV_NUM_W + $clog2(d))) / 64'(d);
		return DIV_MAGIC_W'(q + 64'd1);
	endfunction

	function automatic logic [5:0] div_shift(input int d);
		return 6'(DIV_NUM_W + $clog2(d));
	endfunction

	// Tangent series coefficient idx, Q62 built by the convolution identity,
	// then rounded to the working format; zero outside the table
	function automatic logic [63:0] tan_rc(input int idx);
		logic [63:0]  c [TAN_TERMS];
		logic [127:0] p;
		logic [63:0]  acc;
		logic [63:0]  r;
		c[0] = 64'd1 << COEF_FRAC;
		for (int n = 1; n < TAN_TERMS; n++) begin
			acc = 64'd0;
			for (int i = 0; i < n; i++) begin
				p = {64'd0, c[i]} * {64'd0, c[n - 1 - i]};
				p = (p + (128'd1 << (COEF_FRAC - 1))) >> COEF_FRAC;
				if (p > {64'd0, MAG_MAX})
					p = {64'd0, MAG_MAX};
				acc = acc + p[63:0];
			end
			c[n] = acc / 64'(2 * n + 1);
		end
		r = 64'd0;
		if (idx >= 0 && idx < TAN_TERMS)
			r = (c[idx] >> (COEF_FRAC - WORK_FRAC))
				+ ((c[idx] >> (COEF_FRAC - WORK_FRAC - 1)) & 64'd1);
		return r;
	endfunction

endpackage

// ----- hdl/tsc_mul.sv -----
// Two-stage 64x64 magnitude multiplier with rounded right shift and cap.
// Depends on tsc_pkg.
module tsc_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [63:0] a_mag,
	input  logic [63:0] b_mag,
	input  logic        neg,
	input  logic [5:0]  shift,
	output logic        out_valid,
	output logic [63:0] mag,
	output logic        out_neg
);

	logic        valid_s1;
	logic [63:0] p00_s1, p01_s1, p10_s1, p11_s1;
	logic        neg_s1;
	logic [5:0]  shift_s1;
	logic        valid_s2;
	logic [63:0] mag_s2;
	logic        neg_s2;
	logic [127:0] sum;
	logic [127:0] rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: four 32x32 partial products
	always_ff @(posedge clk) begin
		p00_s1   <= {32'd0, a_mag[31:0]} * {32'd0, b_mag[31:0]};
		p01_s1   <= {32'd0, a_mag[31:0]} * {32'd0, b_mag[63:32]};
		p10_s1   <= {32'd0, a_mag[63:32]} * {32'd0, b_mag[31:0]};
		p11_s1   <= {32'd0, a_mag[63:32]} * {32'd0, b_mag[63:32]};
		neg_s1   <= neg;
		shift_s1 <= shift;
	end

	// Stage 2: combine, round half up on the magnitude, shift, cap
	always_comb begin
		sum = {64'd0, p00_s1} + {32'd0, p01_s1, 32'd0} + {32'd0, p10_s1, 32'd0}
			+ {p11_s1, 64'd0} + (128'd1 << (shift_s1 - 6'd1));
		rnd = sum >> shift_s1;
	end

	always_ff @(posedge clk) begin
		mag_s2 <= (|rnd[127:63]) ? tsc_pkg::MAG_MAX : rnd[63:0];
		neg_s2 <= neg_s1;
	end

	assign out_valid = valid_s2;
	assign mag       = mag_s2;
	assign out_neg   = neg_s2;

endmodule

// ----- hdl/tsc_step.sv -----
// One series term for cosine and sine plus one Horner step of the tangent:
// multiply by x^2, divide by a constant via reciprocal multiply, accumulate.
// Depends on tsc_pkg and tsc_mul.
module tsc_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  tsc_pkg::ctx_t      in_ctx,
	input  tsc_pkg::step_cfg_t cfg,
	output logic               out_valid,
	output tsc_pkg::ctx_t      out_ctx
);

	typedef struct packed {
		logic [63:0]                   w;
		logic [tsc_pkg::DIV_W-1:0]     rem;
		logic [tsc_pkg::DIV_NUM_W-1:0] num;
		logic [tsc_pkg::DIG_W-1:0]     qd;
		logic                          neg;
	} lane_t;

	typedef struct packed {
		tsc_pkg::ctx_t ctx;
		lane_t         c;
		lane_t         s;
	} stg_t;

	logic          cm_valid;
	logic [63:0]   cm_mag, sm_mag, tm_mag;
	logic          cm_neg, sm_neg, tm_neg;
	logic [63:0]   tan_in_mag;
	tsc_pkg::ctx_t ctx_s1, ctx_s2;
	stg_t          stg_in;
	stg_t          stg_nx [tsc_pkg::DIV_STAGES];
	stg_t          stg_s  [tsc_pkg::DIV_STAGES];
	logic [tsc_pkg::DIV_STAGES-1:0] stg_valid_s;
	tsc_pkg::ctx_t ctx_nx;
	tsc_pkg::ctx_t ctx_s11;
	logic          valid_s11;

	// Quotient digit: top digit joined to the remainder, times the reciprocal
	function automatic lane_t dig_mul(input lane_t l,
		input logic [tsc_pkg::DIV_MAGIC_W-1:0] m, input logic [5:0] sh);
		logic [tsc_pkg::DIV_PROD_W-1:0] p;
		lane_t                          r;
		r     = l;
		r.num = {l.rem, l.w[63 -: tsc_pkg::DIG_W]};
		p     = tsc_pkg::DIV_PROD_W'(r.num) * tsc_pkg::DIV_PROD_W'(m);
		r.qd  = tsc_pkg::DIG_W'(p >> sh);
		r.w   = {l.w[63-tsc_pkg::DIG_W:0], {tsc_pkg::DIG_W{1'b0}}};
		return r;
	endfunction

	// New remainder, quotient digit shifted in at the bottom
	function automatic lane_t dig_rem(input lane_t l, input logic [tsc_pkg::DIV_W-1:0] d);
		logic [tsc_pkg::DIV_NUM_W-1:0] qm;
		lane_t                         r;
		r     = l;
		qm    = tsc_pkg::DIV_NUM_W'(l.qd) * tsc_pkg::DIV_NUM_W'(d);
		r.rem = tsc_pkg::DIV_W'(l.num - qm);
		r.w[tsc_pkg::DIG_W-1:0] = l.qd;
		return r;
	endfunction

	assign tan_in_mag = in_ctx.tan_p[63] ? -in_ctx.tan_p : in_ctx.tan_p;

	tsc_mul u_cos_mul (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.a_mag(in_ctx.cos_mag), .b_mag(in_ctx.x2), .neg(in_ctx.cos_neg),
		.shift(tsc_pkg::WORK_SHIFT),
		.out_valid(cm_valid), .mag(cm_mag), .out_neg(cm_neg)
	);

	tsc_mul u_sin_mul (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.a_mag(in_ctx.sin_mag), .b_mag(in_ctx.x2), .neg(in_ctx.sin_neg),
		.shift(tsc_pkg::WORK_SHIFT),
		.out_valid(), .mag(sm_mag), .out_neg(sm_neg)
	);

	tsc_mul u_tan_mul (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.a_mag(tan_in_mag), .b_mag(in_ctx.x2), .neg(in_ctx.tan_p[63]),
		.shift(tsc_pkg::WORK_SHIFT),
		.out_valid(), .mag(tm_mag), .out_neg(tm_neg)
	);

	// Context rides alongside the multipliers
	always_ff @(posedge clk) begin
		ctx_s1 <= in_ctx;
		ctx_s2 <= ctx_s1;
	end

	// Divider entry; tangent Horner add happens here
	always_comb begin
		stg_in       = '0;
		stg_in.ctx   = ctx_s2;
		stg_in.c.w   = cm_mag;
		stg_in.c.neg = cm_neg;
		stg_in.s.w   = sm_mag;
		stg_in.s.neg = sm_neg;
		if (cfg.tan_en)
			stg_in.ctx.tan_p = cfg.tan_coef + (tm_neg ? -tm_mag : tm_mag);
		for (int j = 0; j < tsc_pkg::DIV_STAGES; j++) begin
			stg_nx[j] = (j == 0) ? stg_in : stg_s[j - 1];
			if ((j & 1) == 0) begin
				stg_nx[j].c = dig_mul(stg_nx[j].c, cfg.cos_magic, cfg.cos_sh);
				stg_nx[j].s = dig_mul(stg_nx[j].s, cfg.sin_magic, cfg.sin_sh);
			end else begin
				stg_nx[j].c = dig_rem(stg_nx[j].c, cfg.cos_div);
				stg_nx[j].s = dig_rem(stg_nx[j].s, cfg.sin_div);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_valid_s <= '0;
			valid_s11   <= 1'b0;
		end else begin
			stg_valid_s <= {stg_valid_s[tsc_pkg::DIV_STAGES-2:0], cm_valid};
			valid_s11   <= stg_valid_s[tsc_pkg::DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < tsc_pkg::DIV_STAGES; j++)
			stg_s[j] <= stg_nx[j];
	end

	// New term is the negated quotient; add it to the running sums
	always_comb begin
		ctx_nx = stg_s[tsc_pkg::DIV_STAGES-1].ctx;
		if (cfg.sc_en) begin
			ctx_nx.cos_mag = stg_s[tsc_pkg::DIV_STAGES-1].c.w;
			ctx_nx.cos_neg = ~stg_s[tsc_pkg::DIV_STAGES-1].c.neg;
			ctx_nx.cos_sum = ctx_nx.cos_sum + (stg_s[tsc_pkg::DIV_STAGES-1].c.neg
				? stg_s[tsc_pkg::DIV_STAGES-1].c.w : -stg_s[tsc_pkg::DIV_STAGES-1].c.w);
			ctx_nx.sin_mag = stg_s[tsc_pkg::DIV_STAGES-1].s.w;
			ctx_nx.sin_neg = ~stg_s[tsc_pkg::DIV_STAGES-1].s.neg;
			ctx_nx.sin_sum = ctx_nx.sin_sum + (stg_s[tsc_pkg::DIV_STAGES-1].s.neg
				? stg_s[tsc_pkg::DIV_STAGES-1].s.w : -stg_s[tsc_pkg::DIV_STAGES-1].s.w);
		end
	end

	always_ff @(posedge clk) begin
		ctx_s11 <= ctx_nx;
	end

	assign out_valid = valid_s11;
	assign out_ctx   = ctx_s11;

endmodule

// ----- hdl/taylor_sin_cos_tan.sv -----
// Top level of the degree-input sine/cosine/tangent series evaluator.
// Depends on tsc_pkg, tsc_mul and tsc_step.

// One angle is accepted every cycle (busy is always low) and its result
// appears with a one-cycle done strobe after the input stage, the degree-to-radian
// and squaring multiplies, the chain of series-term stages (each a 64-bit multiply,
// a constant divider and an accumulate), the final tangent multiply and the
// output register. Results are not held: the receiver
// must take each transfer in the cycle that done is high.
module taylor_sin_cos_tan (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [tsc_pkg::ANGLE_W-1:0]  angle_degrees,
	output logic                                done,
	output logic signed [tsc_pkg::RESULT_W-1:0] sine_value,
	output logic signed [tsc_pkg::RESULT_W-1:0] cosine_value,
	output logic signed [tsc_pkg::RESULT_W-1:0] tangent_value,
	output logic                                tangent_saturated
);

	localparam logic signed [63:0] ANG_LIM = 64'sd360 <<< tsc_pkg::ANGLE_FRAC_BITS;
	localparam logic [63:0]        TAN_LIM = 64'd90 << tsc_pkg::ANGLE_FRAC_BITS;
	localparam logic signed [63:0] ONE_RES = 64'sd1 <<< tsc_pkg::RESULT_FRAC_BITS;

	logic signed [63:0] d_clamp;
	logic [63:0]        dm_s1;
	logic               valid_s1, dneg_s1, big_s1;
	logic               dneg_s2, dneg_s3, big_s2, big_s3;
	logic               xv;
	logic [63:0]        x_mag;
	logic               x_neg;
	logic [63:0]        x_mag_s4, x_mag_s5;
	logic               x_neg_s4, x_neg_s5, dneg_s4, dneg_s5, big_s4, big_s5;
	logic               x2v;
	logic [63:0]        x2_mag;
	tsc_pkg::ctx_t      init_ctx;
	logic               step_valid [tsc_pkg::NUM_STEPS+1];
	tsc_pkg::ctx_t      step_ctx   [tsc_pkg::NUM_STEPS+1];
	logic [63:0]        p_mag;
	logic               fv;
	logic [63:0]        f_mag;
	logic               f_neg;
	tsc_pkg::ctx_t      tl_ctx_s1, tl_ctx_s2;
	logic signed [63:0] sv, cv, tp, tv;
	logic               flag;
	logic               done_q;
	logic [tsc_pkg::RESULT_W-1:0] sine_q, cosine_q, tangent_q;
	logic               tsat_q;

	assign busy = 1'b0;

	// Input stage: clamp to +-360 degrees, magnitude and tangent range check
	assign d_clamp = tsc_pkg::clamp64(64'(angle_degrees), ANG_LIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= start;
	end

	always_ff @(posedge clk) begin
		dm_s1   <= d_clamp[63] ? 64'(-d_clamp) : 64'(d_clamp);
		dneg_s1 <= d_clamp[63];
		big_s1  <= ((d_clamp[63] ? 64'(-d_clamp) : 64'(d_clamp)) >= TAN_LIM);
	end

	// Degrees to radians
	tsc_mul u_rad_mul (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s1),
		.a_mag(dm_s1), .b_mag(tsc_pkg::DEG2RAD_Q62), .neg(dneg_s1),
		.shift(tsc_pkg::X_SHIFT),
		.out_valid(xv), .mag(x_mag), .out_neg(x_neg)
	);

	always_ff @(posedge clk) begin
		dneg_s2  <= dneg_s1;
		dneg_s3  <= dneg_s2;
		big_s2   <= big_s1;
		big_s3   <= big_s2;
		x_mag_s4 <= x_mag;
		x_mag_s5 <= x_mag_s4;
		x_neg_s4 <= x_neg;
		x_neg_s5 <= x_neg_s4;
		dneg_s4  <= dneg_s3;
		dneg_s5  <= dneg_s4;
		big_s4   <= big_s3;
		big_s5   <= big_s4;
	end

	// x squared
	tsc_mul u_sq_mul (
		.clk(clk), .arst_n(arst_n), .in_valid(xv),
		.a_mag(x_mag), .b_mag(x_mag), .neg(1'b0),
		.shift(tsc_pkg::WORK_SHIFT),
		.out_valid(x2v), .mag(x2_mag), .out_neg()
	);

	// First terms of each series
	always_comb begin
		init_ctx         = '0;
		init_ctx.x_mag   = x_mag_s5;
		init_ctx.x_neg   = x_neg_s5;
		init_ctx.x2      = x2_mag;
		init_ctx.d_neg   = dneg_s5;
		init_ctx.big     = big_s5;
		init_ctx.cos_mag = tsc_pkg::ONE_WORK;
		init_ctx.cos_neg = 1'b0;
		init_ctx.cos_sum = tsc_pkg::ONE_WORK;
		init_ctx.sin_mag = x_mag_s5;
		init_ctx.sin_neg = x_neg_s5;
		init_ctx.sin_sum = x_neg_s5 ? -x_mag_s5 : x_mag_s5;
		init_ctx.tan_p   = tsc_pkg::tan_rc(tsc_pkg::TAN_TERMS - 1);
	end

	assign step_valid[0] = x2v;
	assign step_ctx[0]   = init_ctx;

	// Term chain
	for (genvar k = 0; k < tsc_pkg::NUM_STEPS; k++) begin : g_step
		localparam int N = k + 1;
		tsc_pkg::step_cfg_t cfg;
		assign cfg.cos_div   = tsc_pkg::DIV_W'((2 * N - 1) * (2 * N));
		assign cfg.cos_magic = tsc_pkg::div_magic((2 * N - 1) * (2 * N));
		assign cfg.cos_sh    = tsc_pkg::div_shift((2 * N - 1) * (2 * N));
		assign cfg.sin_div   = tsc_pkg::DIV_W'((2 * N) * (2 * N + 1));
		assign cfg.sin_magic = tsc_pkg::div_magic((2 * N) * (2 * N + 1));
		assign cfg.sin_sh    = tsc_pkg::div_shift((2 * N) * (2 * N + 1));
		assign cfg.tan_coef  = tsc_pkg::tan_rc(tsc_pkg::TAN_TERMS - 2 - k);
		assign cfg.sc_en     = (k < tsc_pkg::SINCOS_TERMS - 1);
		assign cfg.tan_en    = (k < tsc_pkg::TAN_TERMS - 1);

		tsc_step u_step (
			.clk(clk), .arst_n(arst_n),
			.in_valid(step_valid[k]), .in_ctx(step_ctx[k]), .cfg(cfg),
			.out_valid(step_valid[k+1]), .out_ctx(step_ctx[k+1])
		);
	end

	// Tangent: final multiply by x
	assign p_mag = step_ctx[tsc_pkg::NUM_STEPS].tan_p[63]
		? -step_ctx[tsc_pkg::NUM_STEPS].tan_p : step_ctx[tsc_pkg::NUM_STEPS].tan_p;

	tsc_mul u_tan_mul (
		.clk(clk), .arst_n(arst_n), .in_valid(step_valid[tsc_pkg::NUM_STEPS]),
		.a_mag(p_mag), .b_mag(step_ctx[tsc_pkg::NUM_STEPS].x_mag),
		.neg(step_ctx[tsc_pkg::NUM_STEPS].tan_p[63] ^ step_ctx[tsc_pkg::NUM_STEPS].x_neg),
		.shift(tsc_pkg::WORK_SHIFT),
		.out_valid(fv), .mag(f_mag), .out_neg(f_neg)
	);

	always_ff @(posedge clk) begin
		tl_ctx_s1 <= step_ctx[tsc_pkg::NUM_STEPS];
		tl_ctx_s2 <= tl_ctx_s1;
	end

	// Output formatting, clamps and tangent saturation
	always_comb begin
		sv = tsc_pkg::clamp64(tsc_pkg::round_shift($signed(tl_ctx_s2.sin_sum),
			tsc_pkg::WORK_FRAC - tsc_pkg::RESULT_FRAC_BITS), ONE_RES);
		cv = tsc_pkg::clamp64(tsc_pkg::round_shift($signed(tl_ctx_s2.cos_sum),
			tsc_pkg::WORK_FRAC - tsc_pkg::RESULT_FRAC_BITS), ONE_RES);
		tp = tsc_pkg::round_shift(f_neg ? $signed(-f_mag) : $signed(f_mag),
			tsc_pkg::WORK_FRAC - tsc_pkg::TAN_FRAC);
		tv   = tsc_pkg::clamp64(tp, tsc_pkg::FULL32);
		flag = (tv != tp);
		if (tl_ctx_s2.big) begin
			tv   = tl_ctx_s2.d_neg ? -tsc_pkg::FULL32 : tsc_pkg::FULL32;
			flag = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= fv;
	end

	always_ff @(posedge clk) begin
		sine_q    <= sv[tsc_pkg::RESULT_W-1:0];
		cosine_q  <= cv[tsc_pkg::RESULT_W-1:0];
		tangent_q <= tv[tsc_pkg::RESULT_W-1:0];
		tsat_q    <= flag;
	end

	assign done              = done_q;
	assign sine_value        = $signed(sine_q);
	assign cosine_value      = $signed(cosine_q);
	assign tangent_value     = $signed(tangent_q);
	assign tangent_saturated = tsat_q;

endmodule

// ----- tb/taylor_sin_cos_tan_test.sv -----
// Self-checking testbench for taylor_sin_cos_tan: degree angles in, sine, cosine and
// tangent out, checked against a bit-exact series predictor. Depends on tsc_pkg and the RTL.
`timescale 1ns / 100ps

module taylor_sin_cos_tan_test;

	localparam int PERIOD      = 20;
	localparam int DRAIN_WAIT  = 400;
	localparam int STALL_LIMIT = 5000;
	localparam logic signed [63:0] DEG_LIMIT = 64'sd360 <<< 16;
	localparam logic signed [63:0] TAN_EDGE  = 64'sd90 <<< 16;
	localparam logic [63:0] PI_62  = 64'hC90F_DAA2_2168_C235;
	localparam logic [63:0] RAD_62 = (PI_62 + 64'd90) / 64'd180;
	localparam logic [127:0] I64_MAX = 128'h7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic signed [31:0] sin_q;
		logic signed [31:0] cos_q;
		logic signed [31:0] tan_q;
		logic               tan_sat;
	} trig_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [tsc_pkg::ANGLE_W-1:0] angle_degrees = '0;
	logic busy, done, tangent_saturated;
	logic signed [tsc_pkg::RESULT_W-1:0] sine_value, cosine_value, tangent_value;

	logic signed [tsc_pkg::ANGLE_W-1:0] angle_queue [$];
	trig_t expected_trig [$];
	logic signed [63:0] tan_coef [tsc_pkg::TAN_TERMS];
	int errors = 0, angles_sent = 0, results_seen = 0, saturated_seen = 0;
	int quiet_cycles = 0;
	logic took;

	taylor_sin_cos_tan dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.angle_degrees(angle_degrees), .done(done), .sine_value(sine_value),
		.cosine_value(cosine_value), .tangent_value(tangent_value),
		.tangent_saturated(tangent_saturated)
	);

	always begin
		#(PERIOD / 2) clk = 1'b1;
		#(PERIOD / 2) clk = 1'b0;
	end

	// Fixed-point helpers: rounding half away from zero, magnitude capped
	function automatic logic signed [63:0] round_down(input logic signed [63:0] v, input int s);
		logic [63:0] m;
		m = v[63] ? 64'(-v) : 64'(v);
		m = (m >> s) + ((m >> (s - 1)) & 64'd1);
		if (m > 64'h7FFF_FFFF_FFFF_FFFF)
			m = 64'h7FFF_FFFF_FFFF_FFFF;
		return v[63] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] mul_round(input logic signed [63:0] a,
		input logic signed [63:0] b, input int s);
		logic [63:0] ua, ub;
		logic [127:0] p;
		ua = a[63] ? 64'(-a) : 64'(a);
		ub = b[63] ? 64'(-b) : 64'(b);
		p = {64'd0, ua} * {64'd0, ub};
		p = (p + (128'd1 << (s - 1))) >> s;
		if (p > I64_MAX)
			p = I64_MAX;
		return (a[63] != b[63]) ? -$signed(p[63:0]) : $signed(p[63:0]);
	endfunction

	function automatic logic signed [63:0] limit(input logic signed [63:0] v,
		input logic signed [63:0] lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// Tangent (Bernoulli) coefficients, Q62, by the convolution identity
	task automatic build_tan_coef();
		logic signed [63:0] acc;
		tan_coef[0] = 64'sd1 <<< tsc_pkg::COEF_FRAC;
		for (int n = 1; n < tsc_pkg::TAN_TERMS; n++) begin
			acc = 0;
			for (int i = 0; i < n; i++)
				acc += mul_round(tan_coef[i], tan_coef[n - 1 - i], tsc_pkg::COEF_FRAC);
			tan_coef[n] = acc / 64'(2 * n + 1);
		end
	endtask

	function automatic trig_t series_trig(input logic signed [tsc_pkg::ANGLE_W-1:0] ang);
		trig_t r;
		logic signed [63:0] d, x, x2, t, s_sum, c_sum, p, tv;
		d = limit(64'(ang), DEG_LIMIT);
		x = mul_round(d, $signed(RAD_62),
			tsc_pkg::COEF_FRAC + tsc_pkg::ANGLE_FRAC_BITS - tsc_pkg::WORK_FRAC);
		x2 = mul_round(x, x, tsc_pkg::WORK_FRAC);
		t = 64'sd1 <<< tsc_pkg::WORK_FRAC;
		c_sum = t;
		for (int n = 1; n < tsc_pkg::SINCOS_TERMS; n++) begin
			t = -(mul_round(t, x2, tsc_pkg::WORK_FRAC) / 64'((2 * n - 1) * (2 * n)));
			c_sum += t;
		end
		t = x;
		s_sum = t;
		for (int n = 1; n < tsc_pkg::SINCOS_TERMS; n++) begin
			t = -(mul_round(t, x2, tsc_pkg::WORK_FRAC) / 64'((2 * n) * (2 * n + 1)));
			s_sum += t;
		end
		r.sin_q = 32'(limit(round_down(s_sum, tsc_pkg::WORK_FRAC - tsc_pkg::RESULT_FRAC_BITS),
			64'sd1 <<< tsc_pkg::RESULT_FRAC_BITS));
		r.cos_q = 32'(limit(round_down(c_sum, tsc_pkg::WORK_FRAC - tsc_pkg::RESULT_FRAC_BITS),
			64'sd1 <<< tsc_pkg::RESULT_FRAC_BITS));
		r.tan_sat = 1'b0;
		// Series does not converge at or past a right angle
		if (d >= TAN_EDGE || d <= -TAN_EDGE) begin
			r.tan_sat = 1'b1;
			tv = d[63] ? -tsc_pkg::FULL32 : tsc_pkg::FULL32;
		end else begin
			p = round_down(tan_coef[tsc_pkg::TAN_TERMS - 1],
				tsc_pkg::COEF_FRAC - tsc_pkg::WORK_FRAC);
			for (int n = tsc_pkg::TAN_TERMS - 2; n >= 0; n--)
				p = round_down(tan_coef[n], tsc_pkg::COEF_FRAC - tsc_pkg::WORK_FRAC)
					+ mul_round(p, x2, tsc_pkg::WORK_FRAC);
			p = round_down(mul_round(p, x, tsc_pkg::WORK_FRAC),
				tsc_pkg::WORK_FRAC - tsc_pkg::TAN_FRAC);
			tv = limit(p, tsc_pkg::FULL32);
			if (tv != p)
				r.tan_sat = 1'b1;
		end
		r.tan_q = 32'(tv);
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
			$signed(want), $realtime);
	endtask

	// Driver: one angle per transfer, random idling outside the no-idle stretch
	always @(negedge clk) begin
		if (arst_n && !(start && !took)) begin
			if (angle_queue.size() > 0 && ((angles_sent >= 600 && angles_sent < 900)
				|| $urandom_range(99) >= 16)) begin
				start <= 1'b1;
				angle_degrees <= angle_queue.pop_front();
			end else
				start <= 1'b0;
		end
	end

	// Acceptance, result check and watchdog
	always @(posedge clk) begin
		trig_t w;
		took <= start && !busy;
		if (arst_n && start && !busy) begin
			expected_trig.push_back(series_trig(angle_degrees));
			angles_sent++;
		end
		if (arst_n && done) begin
			results_seen++;
			if (tangent_saturated)
				saturated_seen++;
			if (expected_trig.size() == 0) begin
				errors++;
				$display("unexpected result transfer at %0t", $realtime);
			end else begin
				w = expected_trig.pop_front();
				if (sine_value !== w.sin_q)
					report("sine", sine_value, w.sin_q);
				if (cosine_value !== w.cos_q)
					report("cosine", cosine_value, w.cos_q);
				if (tangent_value !== w.tan_q)
					report("tangent", tangent_value, w.tan_q);
				if (tangent_saturated !== w.tan_sat)
					report("tan_sat", 32'(tangent_saturated), 32'(w.tan_sat));
			end
		end
		quiet_cycles <= ((start && !busy) || done) ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("taylor_sin_cos_tan_test: FAIL");
			$finish;
		end
	end

	function automatic logic signed [tsc_pkg::ANGLE_W-1:0] random_angle();
		case ($urandom_range(3))
			0: return tsc_pkg::ANGLE_W'($signed($urandom_range(2 * 5898240)) - 5898240);
			1: return tsc_pkg::ANGLE_W'($urandom());
			default: return tsc_pkg::ANGLE_W'($signed($urandom_range(2 * 23592960))
				- 23592960);
		endcase
	endfunction

	initial begin
		static int deg [] = '{0, 1, -1, 45, -45, 89, -89, 90, -90, 180, -180, 270, -270,
			360, -360, 361, -361};
		build_tan_coef();
		foreach (deg[k])
			angle_queue.push_back(tsc_pkg::ANGLE_W'(deg[k] * 65536));
		// Just below a right angle, field extremes and smallest step
		angle_queue.push_back(tsc_pkg::ANGLE_W'(90 * 65536 - 1));
		angle_queue.push_back(tsc_pkg::ANGLE_W'(-90 * 65536 + 1));
		angle_queue.push_back({1'b1, {(tsc_pkg::ANGLE_W - 1){1'b0}}});
		angle_queue.push_back({1'b0, {(tsc_pkg::ANGLE_W - 1){1'b1}}});
		angle_queue.push_back(tsc_pkg::ANGLE_W'(-1));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (700)
			angle_queue.push_back(random_angle());
		// Let the pipeline drain completely before the rest
		wait (angle_queue.size() == 0 && !start && expected_trig.size() == 0);
		repeat (800)
			angle_queue.push_back(random_angle());
		wait (angle_queue.size() == 0 && !start && expected_trig.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d angles over +-2^25 LSB incl. clamp and right-angle cases",
			angles_sent);
		$display("checked %0d results, %0d with tangent saturated", results_seen,
			saturated_seen);
		if (errors == 0 && expected_trig.size() == 0)
			$display("taylor_sin_cos_tan_test: PASS");
		else
			$display("taylor_sin_cos_tan_test: FAIL");
		$finish;
	end

endmodule
